[rtl/core/quadratic_root_solver_assert.svh]
// assertion macros shared by the quadratic root solver rtl
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// condition holds at every edge out of reset
`define QRS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("qrs: invariant violated");

// antecedent implies consequent in the same cycle
`define QRS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrs: implication violated");

`endif

[rtl/core/qrs_pkg.sv]
// shared widths, result kind codes and pipeline sideband types of the root solver
// no dependencies
`timescale 1ns / 1ps

package qrs_pkg;

   localparam int COEF_W     = 16;
   localparam int VALUE_W    = 32;
   localparam int DN_W       = 34;   // signed discriminant, magnitude also held in 34 bits
   localparam int ROOT_W     = 33;   // floor sqrt of |dn| * 2^32
   localparam int SQ_STEPS   = 33;   // one root bit per stage
   localparam int SQ_SHIFT   = 32;   // radicand is |dn| shifted up by this
   localparam int SQ_REM_W   = 36;
   localparam int NB_W       = 33;   // -b * 2^16
   localparam int NUM_W      = 35;   // signed numerator
   localparam int NUM_MAG_W  = 34;   // numerator magnitude, also quotient width
   localparam int DEN_W      = 17;   // magnitude of 2a

   typedef enum logic [1:0] {
      KIND_TWO_REAL = 2'd0,
      KIND_DOUBLE   = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_A_ZERO   = 2'd3
   } root_kind_type;

   typedef struct packed {
      root_kind_type           kind;
      logic signed [NB_W-1:0]  nb;
      logic                    den_neg;
      logic [DEN_W-1:0]        den_mag;
   } sqrt_side_type;

   typedef struct packed {
      root_kind_type kind;
      logic          q1_neg;
      logic          q2_neg;
   } div_side_type;

endpackage

[rtl/core/qrs_sqrt.sv]
// pipelined floor square root of |dn| * 2^32, one root bit per register stage
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [qrs_pkg::DN_W-1:0]      in_mag,
   input  qrs_pkg::sqrt_side_type        in_side,
   output logic                          out_valid,
   output logic [qrs_pkg::ROOT_W-1:0]    out_root,
   output qrs_pkg::sqrt_side_type        out_side
);
   import qrs_pkg::*;

   localparam int TW  = SQ_REM_W + 2;
   localparam int PAD = TW - ROOT_W - 2;

   logic                  valid_ff [SQ_STEPS];
   logic [DN_W-1:0]       d_ff     [SQ_STEPS];
   logic [SQ_REM_W-1:0]   rem_ff   [SQ_STEPS];
   logic [ROOT_W-1:0]     root_ff  [SQ_STEPS];
   sqrt_side_type         side_ff  [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam int I = SQ_STEPS - 1 - k;
      logic                v_cur;
      logic [DN_W-1:0]     d_cur;
      logic [SQ_REM_W-1:0] rem_cur;
      logic [ROOT_W-1:0]   root_cur;
      sqrt_side_type       side_cur;
      logic [1:0]          pair;
      logic [TW-1:0]       t;
      logic [TW-1:0]       trial;
      logic [TW-1:0]       diff;
      logic                ge;
      logic [SQ_REM_W-1:0] rem_in;
      logic [ROOT_W-1:0]   root_in;

      if (k == 0) begin : g_head
         assign v_cur    = in_valid;
         assign d_cur    = in_mag;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign side_cur = in_side;
      end else begin : g_body
         assign v_cur    = valid_ff[k-1];
         assign d_cur    = d_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      // low radicand pairs are the zero bits of the 2^32 shift
      if (2 * I >= SQ_SHIFT) begin : g_pair
         assign pair = d_cur[2*I-SQ_SHIFT +: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign t       = {rem_cur, pair};
      assign trial   = {{PAD{1'b0}}, root_cur, 2'b01};
      assign ge      = (t >= trial);
      assign diff    = t - trial;
      assign rem_in  = ge ? diff[SQ_REM_W-1:0] : t[SQ_REM_W-1:0];
      assign root_in = {root_cur[ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         d_ff[k]    <= d_cur;
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_cur;
      end
   end

   assign out_valid = valid_ff[SQ_STEPS-1];
   assign out_root  = root_ff[SQ_STEPS-1];
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

[rtl/core/qrs_div.sv]
// two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [qrs_pkg::NUM_MAG_W-1:0]    in_num1,
   input  logic [qrs_pkg::NUM_MAG_W-1:0]    in_num2,
   input  logic [qrs_pkg::DEN_W-1:0]        in_den,
   input  qrs_pkg::div_side_type            in_side,
   output logic                             out_valid,
   output logic [qrs_pkg::NUM_MAG_W-1:0]    out_q1,
   output logic [qrs_pkg::NUM_MAG_W-1:0]    out_q2,
   output qrs_pkg::div_side_type            out_side
);
   import qrs_pkg::*;

   localparam int NW = NUM_MAG_W;
   localparam int DW = DEN_W;

   logic            valid_ff [NW];
   logic [DW-1:0]   d_ff     [NW];
   logic [NW-1:0]   n1_ff    [NW];
   logic [NW-1:0]   n2_ff    [NW];
   logic [DW-1:0]   r1_ff    [NW];
   logic [DW-1:0]   r2_ff    [NW];
   logic [NW-1:0]   q1_ff    [NW];
   logic [NW-1:0]   q2_ff    [NW];
   div_side_type    side_ff  [NW];

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic          v_cur;
      logic [DW-1:0] d_cur;
      logic [NW-1:0] n1_cur, n2_cur, q1_cur, q2_cur;
      logic [DW-1:0] r1_cur, r2_cur;
      div_side_type  side_cur;
      logic [DW:0]   t1, t2, dd, s1, s2;
      logic          ge1, ge2;

      if (k == 0) begin : g_head
         assign v_cur    = in_valid;
         assign d_cur    = in_den;
         assign n1_cur   = in_num1;
         assign n2_cur   = in_num2;
         assign r1_cur   = '0;
         assign r2_cur   = '0;
         assign q1_cur   = '0;
         assign q2_cur   = '0;
         assign side_cur = in_side;
      end else begin : g_body
         assign v_cur    = valid_ff[k-1];
         assign d_cur    = d_ff[k-1];
         assign n1_cur   = n1_ff[k-1];
         assign n2_cur   = n2_ff[k-1];
         assign r1_cur   = r1_ff[k-1];
         assign r2_cur   = r2_ff[k-1];
         assign q1_cur   = q1_ff[k-1];
         assign q2_cur   = q2_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      assign dd  = {1'b0, d_cur};
      assign t1  = {r1_cur, n1_cur[NW-1]};
      assign t2  = {r2_cur, n2_cur[NW-1]};
      assign ge1 = (t1 >= dd);
      assign ge2 = (t2 >= dd);
      assign s1  = t1 - dd;
      assign s2  = t2 - dd;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         d_ff[k]    <= d_cur;
         n1_ff[k]   <= {n1_cur[NW-2:0], 1'b0};
         n2_ff[k]   <= {n2_cur[NW-2:0], 1'b0};
         r1_ff[k]   <= ge1 ? s1[DW-1:0] : t1[DW-1:0];
         r2_ff[k]   <= ge2 ? s2[DW-1:0] : t2[DW-1:0];
         q1_ff[k]   <= {q1_cur[NW-2:0], ge1};
         q2_ff[k]   <= {q2_cur[NW-2:0], ge2};
         side_ff[k] <= side_cur;
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_q1    = q1_ff[NW-1];
   assign out_q2    = q2_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

[rtl/core/quadratic_root_solver.sv]
// beats pass stages 0-2, the square root, stage 3, the divider and output register
// throughput: one coefficient beat per cycle; busy is never raised
// depth is set by the square root (33 stages) and divider (34 stages) pipelines
// reset clears every valid bit, so beats in flight at reset are dropped
// the receiver cannot stall: each result shows for exactly one cycle
// depends on qrs_pkg, qrs_sqrt, qrs_div and quadratic_root_solver_assert.svh
`timescale 1ns / 1ps

module quadratic_root_solver (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [15:0]  req_coef_a,
   input  logic signed [15:0]  req_coef_b,
   input  logic signed [15:0]  req_coef_c,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_root_kind,
   output logic signed [31:0]  rsp_first_value,
   output logic signed [31:0]  rsp_second_value,
   output logic                rsp_saturated
);
   import qrs_pkg::*;
   `include "quadratic_root_solver_assert.svh"

   localparam logic signed [NUM_W-1:0] SAT_MAX = NUM_W'(64'sd2147483647);
   localparam logic signed [NUM_W-1:0] SAT_MIN = -NUM_W'(64'sd2147483648);

   // stage 0: input register
   logic                      s0_valid_ff;
   logic signed [COEF_W-1:0]  s0_a_ff, s0_b_ff, s0_c_ff;

   // stage 1: products and easy terms
   logic                      s1_valid_ff;
   logic [2*COEF_W-1:0]       s1_bb_ff;
   logic signed [2*COEF_W-1:0] s1_ac_ff;
   logic                      s1_a_zero_ff;
   sqrt_side_type             s1_side_ff;

   // stage 2: discriminant and kind
   logic                      s2_valid_ff;
   logic signed [DN_W-1:0]    s2_dn_ff;
   sqrt_side_type             s2_side_ff;

   // stage 3: numerators
   logic                      s3_valid_ff;
   logic signed [NUM_W-1:0]   s3_num1_ff, s3_num2_ff;
   sqrt_side_type             s3_side_ff;

   // output register
   logic                      out_valid_ff;
   root_kind_type             out_kind_ff;
   logic signed [VALUE_W-1:0] out_first_ff, out_second_ff;
   logic                      out_sat_ff;

   logic                      accept;
   logic signed [COEF_W:0]    neg_b;
   logic [COEF_W-1:0]         abs_a;
   sqrt_side_type             s1_side_in, s2_side_in;
   logic signed [DN_W-1:0]    dn_in;
   logic [DN_W-1:0]           sq_mag;
   logic                      sq_valid;
   logic [ROOT_W-1:0]         sq_root;
   sqrt_side_type             sq_side;
   logic signed [NUM_W-1:0]   root_ext, nb_ext, num1_in, num2_in;
   logic signed [NUM_W-1:0]   mag1_full, mag2_full;
   div_side_type              dv_side_in, dv_side;
   logic                      dv_valid;
   logic [NUM_MAG_W-1:0]      dv_q1, dv_q2;
   logic signed [NUM_W-1:0]   qs1, qs2;
   logic                      clip1, clip2;
   logic signed [VALUE_W-1:0] v1_in, v2_in;

   function automatic logic signed [VALUE_W-1:0] sat_value(
      input logic signed [NUM_W-1:0] v, output logic clip);
      logic signed [VALUE_W-1:0] r;
      if (v > SAT_MAX) begin
         r    = SAT_MAX[VALUE_W-1:0];
         clip = 1'b1;
      end else if (v < SAT_MIN) begin
         r    = SAT_MIN[VALUE_W-1:0];
         clip = 1'b1;
      end else begin
         r    = v[VALUE_W-1:0];
         clip = 1'b0;
      end
      return r;
   endfunction

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= accept;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= sq_valid;
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      s0_a_ff <= req_coef_a;
      s0_b_ff <= req_coef_b;
      s0_c_ff <= req_coef_c;
   end

   // stage 1
   assign neg_b = -{s0_b_ff[COEF_W-1], s0_b_ff};
   assign abs_a = s0_a_ff[COEF_W-1] ? COEF_W'(-s0_a_ff) : COEF_W'(s0_a_ff);

   always_comb begin
      s1_side_in         = '0;
      s1_side_in.kind    = KIND_A_ZERO;
      s1_side_in.nb      = {neg_b, {(NB_W-COEF_W-1){1'b0}}};
      s1_side_in.den_neg = s0_a_ff[COEF_W-1];
      s1_side_in.den_mag = {abs_a, 1'b0};
   end

   always_ff @(posedge clock) begin
      s1_bb_ff     <= (2*COEF_W)'(s0_b_ff * s0_b_ff);
      s1_ac_ff     <= s0_a_ff * s0_c_ff;
      s1_a_zero_ff <= (s0_a_ff == '0);
      s1_side_ff   <= s1_side_in;
   end

   // stage 2
   assign dn_in = $signed({{(DN_W-2*COEF_W){1'b0}}, s1_bb_ff})
                - ($signed({{(DN_W-2*COEF_W){s1_ac_ff[2*COEF_W-1]}}, s1_ac_ff}) <<< 2);

   always_comb begin
      s2_side_in = s1_side_ff;
      if (s1_a_zero_ff) begin
         s2_side_in.kind = KIND_A_ZERO;
      end else if (dn_in > 0) begin
         s2_side_in.kind = KIND_TWO_REAL;
      end else if (dn_in == 0) begin
         s2_side_in.kind = KIND_DOUBLE;
      end else begin
         s2_side_in.kind = KIND_COMPLEX;
      end
   end

   always_ff @(posedge clock) begin
      s2_dn_ff   <= dn_in;
      s2_side_ff <= s2_side_in;
   end

   assign sq_mag = s2_dn_ff[DN_W-1] ? DN_W'(-s2_dn_ff) : DN_W'(s2_dn_ff);

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_mag    (sq_mag),
      .in_side   (s2_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage 3: numerators per kind
   assign root_ext = $signed({{(NUM_W-ROOT_W){1'b0}}, sq_root});
   assign nb_ext   = $signed({{(NUM_W-NB_W){sq_side.nb[NB_W-1]}}, sq_side.nb});

   always_comb begin
      num1_in = nb_ext;
      num2_in = '0;
      case (sq_side.kind)
         KIND_TWO_REAL: begin
            num1_in = nb_ext + root_ext;
            num2_in = nb_ext - root_ext;
         end
         KIND_COMPLEX: begin
            num2_in = root_ext;
         end
         default: begin
            num2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s3_num1_ff <= num1_in;
      s3_num2_ff <= num2_in;
      s3_side_ff <= sq_side;
   end

   assign mag1_full = s3_num1_ff[NUM_W-1] ? -s3_num1_ff : s3_num1_ff;
   assign mag2_full = s3_num2_ff[NUM_W-1] ? -s3_num2_ff : s3_num2_ff;

   always_comb begin
      dv_side_in.kind   = s3_side_ff.kind;
      dv_side_in.q1_neg = s3_num1_ff[NUM_W-1] ^ s3_side_ff.den_neg;
      dv_side_in.q2_neg = s3_num2_ff[NUM_W-1] ^ s3_side_ff.den_neg;
   end

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num1   (mag1_full[NUM_MAG_W-1:0]),
      .in_num2   (mag2_full[NUM_MAG_W-1:0]),
      .in_den    (s3_side_ff.den_mag),
      .in_side   (dv_side_in),
      .out_valid (dv_valid),
      .out_q1    (dv_q1),
      .out_q2    (dv_q2),
      .out_side  (dv_side)
   );

   // sign, saturation, a-is-zero override
   assign qs1 = dv_side.q1_neg ? -$signed({1'b0, dv_q1}) : $signed({1'b0, dv_q1});
   assign qs2 = dv_side.q2_neg ? -$signed({1'b0, dv_q2}) : $signed({1'b0, dv_q2});

   always_comb begin
      v1_in = sat_value(qs1, clip1);
      v2_in = sat_value(qs2, clip2);
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= dv_side.kind;
      if (dv_side.kind == KIND_A_ZERO) begin
         out_first_ff  <= '0;
         out_second_ff <= '0;
         out_sat_ff    <= 1'b0;
      end else begin
         out_first_ff  <= v1_in;
         out_second_ff <= v2_in;
         out_sat_ff    <= clip1 | clip2;
      end
   end

   assign rsp_strobe       = out_valid_ff;
   assign rsp_root_kind    = out_kind_ff;
   assign rsp_first_value  = out_first_ff;
   assign rsp_second_value = out_second_ff;
   assign rsp_saturated    = out_sat_ff;

   `QRS_ASSERT_IMPLY(a_zero_result_clear, clock, reset, rsp_strobe && rsp_root_kind == KIND_A_ZERO, rsp_first_value == 0 && rsp_second_value == 0 && !rsp_saturated)
   `QRS_ASSERT_IMPLY(a_double_second_zero, clock, reset, rsp_strobe && rsp_root_kind == KIND_DOUBLE, rsp_second_value == 0)
   `QRS_ASSERT_IMPLY(a_sat_at_bound, clock, reset, rsp_strobe && rsp_saturated, rsp_first_value == SAT_MAX[VALUE_W-1:0] || rsp_first_value == SAT_MIN[VALUE_W-1:0] || rsp_second_value == SAT_MAX[VALUE_W-1:0] || rsp_second_value == SAT_MIN[VALUE_W-1:0])

endmodule

[tb/testbench.sv]
// self-checking testbench for quadratic_root_solver: directed and random coefficient beats
// predicts each result in-line from the coefficients; depends on qrs_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
   import qrs_pkg::*;

   typedef struct {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
   } coef_beat_type;

   typedef struct {
      root_kind_type      kind;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
      logic               saturated;
   } roots_type;

   localparam int LATENCY = 72;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_coef_a = '0;
   logic signed [15:0] req_coef_b = '0;
   logic signed [15:0] req_coef_c = '0;
   logic rsp_strobe;
   logic [1:0] rsp_root_kind;
   logic signed [31:0] rsp_first_value;
   logic signed [31:0] rsp_second_value;
   logic rsp_saturated;

   coef_beat_type pending_beats[$];
   roots_type expected_roots[$];
   int send_idle_pct = 0;
   bit hold_for_drain = 1'b0;
   bit stimulus_done = 1'b0;
   int mismatches = 0;
   int roots_checked = 0;
   int idle_cycles = 0;
   int kind_seen[4] = '{0, 0, 0, 0};
   int sat_seen = 0;

   quadratic_root_solver i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_coef_c(req_coef_c),
      .rsp_strobe(rsp_strobe), .rsp_root_kind(rsp_root_kind),
      .rsp_first_value(rsp_first_value), .rsp_second_value(rsp_second_value),
      .rsp_saturated(rsp_saturated)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // floor(sqrt(d * 2^32)), two radicand bits per pass
   function automatic logic [63:0] isqrt_q16(input logic [63:0] d);
      logic [127:0] rad;
      logic [127:0] rem;
      logic [127:0] root;
      logic [127:0] trial;
      rad = {64'd0, d} << 32;
      rem = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
         trial = (root << 2) | 128'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 128'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic logic signed [31:0] clip32(input longint v, inout logic clipped);
      if (v > 64'sd2147483647) begin
         clipped = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         clipped = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic roots_type solve_roots(input coef_beat_type beat);
      roots_type r;
      longint a;
      longint b;
      longint c;
      longint den;
      longint nb;
      longint disc;
      longint s;
      logic clipped;
      a = beat.a;
      b = beat.b;
      c = beat.c;
      clipped = 1'b0;
      r.kind = KIND_A_ZERO;
      r.first_value = '0;
      r.second_value = '0;
      r.saturated = 1'b0;
      if (a == 0) return r;
      den = 2 * a;
      nb = -b * 65536;
      disc = b * b - 4 * a * c;
      if (disc > 0) begin
         s = longint'(isqrt_q16(disc));
         r.kind = KIND_TWO_REAL;
         r.first_value = clip32((nb + s) / den, clipped);
         r.second_value = clip32((nb - s) / den, clipped);
      end else if (disc == 0) begin
         r.kind = KIND_DOUBLE;
         r.first_value = clip32(nb / den, clipped);
      end else begin
         s = longint'(isqrt_q16(-disc));
         r.kind = KIND_COMPLEX;
         r.first_value = clip32(nb / den, clipped);
         r.second_value = clip32(s / den, clipped);
      end
      r.saturated = clipped;
      return r;
   endfunction

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'(signed'($urandom_range(0, 6)) - 3);
         4, 5: return 16'(signed'($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_beat(input int a, input int b, input int c);
      coef_beat_type beat;
      beat.a = 16'(a);
      beat.b = 16'(b);
      beat.c = 16'(c);
      pending_beats.push_back(beat);
   endtask

   task automatic queue_random(input int count);
      coef_beat_type beat;
      int r;
      for (int i = 0; i < count; i++) begin
         beat.a = pick_coef();
         beat.b = pick_coef();
         beat.c = pick_coef();
         r = $urandom_range(0, 9);
         // steer some beats onto a zero discriminant: b = 2k, a*c = k*k
         if (r == 0) begin
            r = $urandom_range(0, 181);
            beat.a = 16'(r);
            beat.c = 16'(r);
            beat.b = ($urandom_range(0, 1) ? 16'(2 * r) : -16'(2 * r));
            if ($urandom_range(0, 1)) begin
               beat.a = -beat.a;
               beat.c = -beat.c;
            end
         end
         pending_beats.push_back(beat);
      end
   endtask

   // driver: one beat offered at a time, start held while beats keep coming
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         automatic bit fire = start && !busy;
         automatic bit have_next;
         if (fire) void'(pending_beats.pop_front());
         have_next = pending_beats.size() > 0 && !hold_for_drain &&
                     ($urandom_range(0, 99) >= send_idle_pct);
         if (start && !fire) begin
            // beat still waiting for acceptance, keep it on the bus
         end else if (have_next) begin
            start <= 1'b1;
            req_coef_a <= pending_beats[0].a;
            req_coef_b <= pending_beats[0].b;
            req_coef_c <= pending_beats[0].c;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on each accepted beat, check each strobed result
   always @(posedge clock) begin
      if (!reset) begin
         automatic bit accepted = 1'b0;
         if (start && !busy) begin
            automatic coef_beat_type beat;
            beat.a = req_coef_a;
            beat.b = req_coef_b;
            beat.c = req_coef_c;
            expected_roots.push_back(solve_roots(beat));
            accepted = 1'b1;
         end
         if (rsp_strobe) begin
            accepted = 1'b1;
            if (expected_roots.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
               automatic roots_type exp_r = expected_roots.pop_front();
               roots_checked++;
               kind_seen[exp_r.kind]++;
               if (exp_r.saturated) sat_seen++;
               if (rsp_root_kind !== exp_r.kind || rsp_first_value !== exp_r.first_value ||
                   rsp_second_value !== exp_r.second_value ||
                   rsp_saturated !== exp_r.saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: kind %0d/%0d first %0d/%0d second %0d/%0d sat %0b/%0b",
                              exp_r.kind, rsp_root_kind, exp_r.first_value, rsp_first_value,
                              exp_r.second_value, rsp_second_value, exp_r.saturated,
                              rsp_saturated);
               end
            end
         end
         idle_cycles = accepted ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      // extremes, each root kind, negative a with complex pair, saturation
      queue_beat(0, 5, 7);
      queue_beat(0, -32768, 32767);
      queue_beat(256, 0, -1024);
      queue_beat(256, -512, 256);
      queue_beat(256, 0, 256);
      queue_beat(-256, 0, -256);
      queue_beat(-256, 512, -512);
      queue_beat(1, 32767, 0);
      queue_beat(1, -32768, 0);
      queue_beat(-1, -32768, 32767);
      queue_beat(-32768, -32768, -32768);
      queue_beat(32767, 32767, 32767);
      queue_beat(-32768, 32767, 32767);
      queue_beat(1, 0, 32767);
      queue_beat(-1, 0, 32767);
      queue_beat(1, 2, 1);
      queue_beat(-1, 2, -1);
      queue_beat(181, 362, 181);
      queue_beat(32767, -32768, -32768);
      queue_beat(-1, -1, -1);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 32;
      queue_random(600);
      wait (pending_beats.size() == 0);
      // hold off until the pipe has emptied
      hold_for_drain = 1'b1;
      wait (expected_roots.size() == 0);
      @(posedge clock);
      hold_for_drain = 1'b0;
      send_idle_pct = 52;
      queue_random(500);
      wait (pending_beats.size() == 0);
      send_idle_pct = 0;
      queue_random(530);
      wait (pending_beats.size() == 0);
      wait (expected_roots.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);

      $display("checked %0d results: %0d two-real, %0d double, %0d complex, %0d a-zero",
               roots_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("%0d saturated results, %0d mismatches", sat_seen, mismatches);
      if (mismatches == 0 && expected_roots.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
